@@ sv/abpt_pkg.sv @@
`timescale 1ns / 1ps

package abpt_pkg;

    localparam int BPM_W    = 8;
    localparam int MS_W     = 16;
    localparam int PULSE_W  = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = PULSE_W;

    localparam int DIV_STEPS = MS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MS_W-1:0]    BEAT_NUMERATOR_MS = MS_W'(60000);
    localparam logic [PULSE_W-1:0] PULSE_LEN_RESET   = PULSE_W'(235);

    localparam logic [CFG_IDX_W-1:0] CFG_IS_PRIMARY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN  = CFG_IDX_W'(1);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SYNC = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    typedef struct packed {
        logic exec_now;
        logic sync_load;
        logic div_step;
        logic sync_apply;
    } t_dp_cmd;

    typedef struct packed {
        logic sync_run;
    } t_dp_stat;

endpackage

@@ sv/abpt_if.sv @@
`timescale 1ns / 1ps

interface abpt_in_if;
    import abpt_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic                play;
    logic [BPM_W-1:0]    beats_per_minute;
    logic [MS_W-1:0]     phase_ms;
    logic                next_beat_right;

    modport source (
        output valid, opcode, play, beats_per_minute, phase_ms, next_beat_right,
        input  ready
    );
    modport sink (
        input  valid, opcode, play, beats_per_minute, phase_ms, next_beat_right,
        output ready
    );
endinterface

interface abpt_out_if;
    logic valid;
    logic ready;
    logic motor_on;

    modport source (output valid, motor_on, input ready);
    modport sink   (input valid, motor_on, output ready);
endinterface

@@ sv/abpt_ctrl.sv @@
`timescale 1ns / 1ps

module abpt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  abpt_pkg::t_dp_stat i_stat,
    output abpt_pkg::t_dp_cmd  o_cmd
);
    import abpt_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;
    logic                 in_acc;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_stat.sync_run) begin
                        o_cmd.sync_load = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_DIV;
                    end else begin
                        o_cmd.exec_now = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    o_cmd.sync_apply = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.exec_now, o_cmd.sync_load, o_cmd.div_step, o_cmd.sync_apply}))
        else $error("more than one datapath command");

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sync_load |=> (r_state == S_DIV) && (r_cnt == '0))
        else $error("sync load did not start the divider");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_APPLY))
        else $error("divider did not finish after all steps");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec_now || o_cmd.sync_apply) |=> r_out_valid)
        else $error("state update without a result item");
`endif

endmodule

@@ sv/abpt_dp.sv @@
`timescale 1ns / 1ps

module abpt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [abpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [abpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_opcode,
    input  logic                                i_play,
    input  logic [abpt_pkg::BPM_W-1:0]          i_bpm,
    input  logic [abpt_pkg::MS_W-1:0]           i_offset,
    input  logic                                i_nbr,
    input  abpt_pkg::t_dp_cmd                   i_cmd,
    output abpt_pkg::t_dp_stat                  o_stat,
    output logic                                o_motor_on
);
    import abpt_pkg::*;

    // configuration
    logic               r_is_primary;
    logic [PULSE_W-1:0] r_pulse_len;

    // timer state
    logic               r_running, n_running;
    logic               r_nsr, n_nsr;
    logic [MS_W-1:0]    r_period, n_period;
    logic [MS_W-1:0]    r_countdown, n_countdown;
    logic [PULSE_W-1:0] r_pulse_rem, n_pulse_rem;
    logic               r_motor, n_motor;

    // latched sync fields and divider
    logic [MS_W-1:0]    r_sync_offset;
    logic               r_sync_nbr;
    logic [BPM_W-1:0]   r_div;
    logic [MS_W-1:0]    r_quo;
    logic [BPM_W-1:0]   r_rem;
    logic [BPM_W:0]     trial;
    logic               q_bit;

    assign o_stat.sync_run = (i_opcode == OP_SYNC) && i_play && (i_bpm != '0);
    assign o_motor_on      = r_motor;

    assign trial = {r_rem, r_quo[MS_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_primary <= 1'b0;
            r_pulse_len  <= PULSE_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IS_PRIMARY: r_is_primary <= i_cfg_data[0];
                CFG_PULSE_LEN:  r_pulse_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sync_load) begin
            r_sync_offset <= i_offset;
            r_sync_nbr    <= i_nbr;
            r_div         <= i_bpm;
            r_quo         <= BEAT_NUMERATOR_MS;
            r_rem         <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[MS_W-2:0], q_bit};
            r_rem <= q_bit ? BPM_W'(trial - {1'b0, r_div}) : trial[BPM_W-1:0];
        end
    end

    always_comb begin
        n_running   = r_running;
        n_nsr       = r_nsr;
        n_period    = r_period;
        n_countdown = r_countdown;
        n_pulse_rem = r_pulse_rem;
        n_motor     = r_motor;
        if (i_cmd.exec_now) begin
            if (i_opcode == OP_SYNC) begin
                // stop
                n_running   = 1'b0;
                n_pulse_rem = '0;
                n_motor     = 1'b0;
            end else begin
                if (r_pulse_rem != '0) begin
                    n_pulse_rem = r_pulse_rem - PULSE_W'(1);
                    if (r_pulse_rem == PULSE_W'(1)) begin
                        n_motor = 1'b0;
                    end
                end
                if (r_running) begin
                    if (r_countdown > MS_W'(1)) begin
                        n_countdown = r_countdown - MS_W'(1);
                    end else begin
                        if (r_nsr == r_is_primary) begin
                            n_pulse_rem = r_pulse_len;
                            n_motor     = (r_pulse_len != '0);
                        end
                        n_nsr       = ~r_nsr;
                        n_countdown = r_period;
                    end
                end
            end
        end else if (i_cmd.sync_apply) begin
            n_nsr     = r_sync_nbr;
            n_period  = r_quo;
            n_running = 1'b1;
            if (r_sync_offset < r_quo) begin
                n_countdown = r_quo - r_sync_offset;
            end else begin
                n_countdown = r_quo;
            end
            if ((r_sync_offset < {{(MS_W-PULSE_W){1'b0}}, r_pulse_len})
                && ((~r_sync_nbr) == r_is_primary)) begin
                n_pulse_rem = r_pulse_len - r_sync_offset[PULSE_W-1:0];
                n_motor     = (r_pulse_len != r_sync_offset[PULSE_W-1:0]);
            end else begin
                n_pulse_rem = '0;
                n_motor     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_nsr       <= 1'b0;
            r_period    <= '0;
            r_countdown <= '0;
            r_pulse_rem <= '0;
            r_motor     <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_nsr       <= n_nsr;
            r_period    <= n_period;
            r_countdown <= n_countdown;
            r_pulse_rem <= n_pulse_rem;
            r_motor     <= n_motor;
        end
    end

endmodule

@@ sv/alternating_beat_pulse_timer.sv @@
// A tick or stop sync gives its result item in the cycle after it is accepted.
// A running sync goes through a load, 16 steps of the restoring divider that
// forms 60000 / bpm one quotient bit per cycle, and an apply step.
// One tick per cycle unless the output stalls; a running sync blocks new items.
// Reset (synchronous, active low) stops the timer, turns the motor off,
// clears is_primary and sets pulse_length_ms to 235.
`timescale 1ns / 1ps

module alternating_beat_pulse_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    abpt_in_if.sink                         i_in,
    abpt_out_if.source                      o_out
);
    import abpt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    abpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    abpt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_in.opcode),
        .i_play     (i_in.play),
        .i_bpm      (i_in.beats_per_minute),
        .i_offset   (i_in.phase_ms),
        .i_nbr      (i_in.next_beat_right),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_motor_on (o_out.motor_on)
    );

endmodule
